>>> rtl/union_find_table_assert.svh
`ifndef UNION_FIND_TABLE_ASSERT_SVH
`define UNION_FIND_TABLE_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define UFT_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define UFT_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> rtl/uft_pkg.sv
package uft_pkg;

    localparam int NODES = 1024;
    localparam int ADDR_W = $clog2(NODES);
    localparam int SIZE_W = $clog2(NODES + 1);
    localparam int IDX_W = 10;
    localparam int CNT_W = 11;
    localparam int RESET_COUNT = 1024;
    localparam int RESET_ACTIVE = (RESET_COUNT > NODES) ? NODES : RESET_COUNT;

    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_MERGE = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND_START,
        ST_FIND_UP,
        ST_COMPRESS,
        ST_FIND_DONE,
        ST_SIZE_A,
        ST_SIZE_B,
        ST_SIZE_WAIT,
        ST_MERGE,
        ST_FIX,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic clear_step;
        logic find_start;
        logic find_up;
        logic compress;
        logic find_done;
        logic size_ra;
        logic size_rb;
        logic size_wait;
        logic merge;
        logic fix;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic in_bad;
        logic link_is_top;
        logic node_is_top;
        logic second;
        logic need_fix;
        logic out_busy;
        logic clear_last;
    } dp_status_t;

endpackage

>>> rtl/uft_ram.sv
module uft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/uft_ctrl.sv
module uft_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  uft_pkg::dp_status_t  status,
    output uft_pkg::dp_cmd_t     cmd
);

    uft_pkg::ctrl_state_t state_reg;
    uft_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= uft_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            uft_pkg::ST_CLEAR: begin
                if (status.clear_last) begin
                    state_next = uft_pkg::ST_IDLE;
                end
            end
            uft_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = status.in_bad ? uft_pkg::ST_DONE : uft_pkg::ST_FIND_START;
                end
            end
            uft_pkg::ST_FIND_START: begin
                state_next = uft_pkg::ST_FIND_UP;
            end
            uft_pkg::ST_FIND_UP: begin
                if (status.link_is_top) begin
                    state_next = status.node_is_top ? uft_pkg::ST_FIND_DONE
                                                    : uft_pkg::ST_COMPRESS;
                end
            end
            uft_pkg::ST_COMPRESS: begin
                if (status.link_is_top) begin
                    state_next = uft_pkg::ST_FIND_DONE;
                end
            end
            uft_pkg::ST_FIND_DONE: begin
                state_next = status.second ? uft_pkg::ST_SIZE_A : uft_pkg::ST_FIND_START;
            end
            uft_pkg::ST_SIZE_A: begin
                state_next = uft_pkg::ST_SIZE_B;
            end
            uft_pkg::ST_SIZE_B: begin
                state_next = uft_pkg::ST_SIZE_WAIT;
            end
            uft_pkg::ST_SIZE_WAIT: begin
                state_next = uft_pkg::ST_MERGE;
            end
            uft_pkg::ST_MERGE: begin
                state_next = status.need_fix ? uft_pkg::ST_FIX : uft_pkg::ST_DONE;
            end
            uft_pkg::ST_FIX: begin
                state_next = uft_pkg::ST_DONE;
            end
            uft_pkg::ST_DONE: begin
                if (!status.out_busy) begin
                    state_next = uft_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = uft_pkg::ST_CLEAR;
            end
        endcase
        if (cfg_wr_en) begin
            state_next = uft_pkg::ST_CLEAR;
        end
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            uft_pkg::ST_CLEAR: begin
                cmd.clear_step = 1'b1;
            end
            uft_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                cmd.accept = s_valid;
            end
            uft_pkg::ST_FIND_START: begin
                cmd.find_start = 1'b1;
            end
            uft_pkg::ST_FIND_UP: begin
                cmd.find_up = 1'b1;
            end
            uft_pkg::ST_COMPRESS: begin
                cmd.compress = 1'b1;
            end
            uft_pkg::ST_FIND_DONE: begin
                cmd.find_done = 1'b1;
            end
            uft_pkg::ST_SIZE_A: begin
                cmd.size_ra = 1'b1;
            end
            uft_pkg::ST_SIZE_B: begin
                cmd.size_rb = 1'b1;
            end
            uft_pkg::ST_SIZE_WAIT: begin
                cmd.size_wait = 1'b1;
            end
            uft_pkg::ST_MERGE: begin
                cmd.merge = 1'b1;
            end
            uft_pkg::ST_FIX: begin
                cmd.fix = 1'b1;
            end
            uft_pkg::ST_DONE: begin
                cmd.out_load = !status.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/uft_dpath.sv
module uft_dpath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [uft_pkg::CNT_W-1:0]   cfg_wr_data,
    input  logic                        s_command,
    input  logic [uft_pkg::IDX_W-1:0]   s_first_index,
    input  logic [uft_pkg::IDX_W-1:0]   s_second_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [uft_pkg::IDX_W-1:0]   m_first_root,
    output logic [uft_pkg::IDX_W-1:0]   m_second_root,
    output logic                        m_same_set,
    output logic                        m_merged,
    output logic [uft_pkg::CNT_W-1:0]   m_set_size,
    output logic [uft_pkg::CNT_W-1:0]   m_set_count,
    output logic                        m_bad_index,
    input  uft_pkg::dp_cmd_t            cmd,
    output uft_pkg::dp_status_t         status
);

    localparam int AW = uft_pkg::ADDR_W;
    localparam int SW = uft_pkg::SIZE_W;
    localparam int CW = uft_pkg::CNT_W;
    localparam int IW = uft_pkg::IDX_W;

    logic [CW-1:0] active_reg, active_next;
    logic [CW-1:0] groups_reg, groups_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          m_valid_reg, m_valid_next;

    logic          cmd_bit_reg, cmd_bit_next;
    logic [AW-1:0] a_reg, a_next;
    logic [AW-1:0] b_reg, b_next;
    logic [AW-1:0] node_reg, node_next;
    logic [AW-1:0] top_reg, top_next;
    logic [AW-1:0] walk_reg, walk_next;
    logic          second_reg, second_next;
    logic          bad_reg, bad_next;
    logic [AW-1:0] ra_reg, ra_next;
    logic [AW-1:0] rb_reg, rb_next;
    logic [SW-1:0] size_a_reg, size_a_next;
    logic [SW-1:0] size_b_reg, size_b_next;
    logic [AW-1:0] keep_reg, keep_next;
    logic          merged_reg, merged_next;
    logic [SW-1:0] set_size_reg, set_size_next;

    logic [IW-1:0] out_ra_reg, out_ra_next;
    logic [IW-1:0] out_rb_reg, out_rb_next;
    logic          out_same_reg, out_same_next;
    logic          out_merged_reg, out_merged_next;
    logic [CW-1:0] out_size_reg, out_size_next;
    logic [CW-1:0] out_count_reg, out_count_next;
    logic          out_bad_reg, out_bad_next;

    logic          p_we;
    logic [AW-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
    logic          z_we;
    logic [AW-1:0] z_waddr, z_raddr;
    logic [SW-1:0] z_wdata, z_rdata;

    logic [CW-1:0] cfg_active;
    logic          do_merge;
    logic [AW-1:0] keep_c, gone_c;
    logic [SW-1:0] size_sum;

    assign cfg_active = (int'(cfg_wr_data) > uft_pkg::NODES) ? CW'(uft_pkg::NODES)
                                                            : cfg_wr_data;
    assign do_merge = (cmd_bit_reg == uft_pkg::CMD_MERGE) && (ra_reg != rb_reg);
    assign keep_c = (size_a_reg < size_b_reg) ? rb_reg : ra_reg;
    assign gone_c = (size_a_reg < size_b_reg) ? ra_reg : rb_reg;
    assign size_sum = size_a_reg + size_b_reg;

    always_comb begin
        status.in_bad = (CW'(s_first_index) >= active_reg) ||
                        (CW'(s_second_index) >= active_reg);
        status.link_is_top = (p_rdata == top_reg);
        status.node_is_top = (node_reg == top_reg);
        status.second = second_reg;
        status.need_fix = do_merge && (keep_c == rb_reg) && (a_reg != ra_reg);
        status.out_busy = m_valid_reg && !m_ready;
        status.clear_last = (clr_reg == AW'(uft_pkg::NODES - 1));
    end

    always_comb begin
        p_raddr = node_reg;
        if (cmd.find_up && !status.link_is_top) begin
            p_raddr = p_rdata;
        end else if (cmd.compress) begin
            p_raddr = p_rdata;
        end

        p_we = 1'b0;
        p_waddr = clr_reg;
        p_wdata = clr_reg;
        if (cmd.clear_step) begin
            p_we = 1'b1;
        end else if (cmd.compress) begin
            p_we = 1'b1;
            p_waddr = walk_reg;
            p_wdata = top_reg;
        end else if (cmd.merge && do_merge) begin
            p_we = 1'b1;
            p_waddr = gone_c;
            p_wdata = keep_c;
        end else if (cmd.fix) begin
            p_we = 1'b1;
            p_waddr = a_reg;
            p_wdata = keep_reg;
        end

        z_raddr = cmd.size_ra ? ra_reg : rb_reg;
        z_we = cmd.clear_step || (cmd.merge && do_merge);
        z_waddr = cmd.clear_step ? clr_reg : keep_c;
        z_wdata = cmd.clear_step ? SW'(1) : size_sum;
    end

    uft_ram #(
        .WIDTH (AW),
        .DEPTH (uft_pkg::NODES)
    ) u_parent_ram (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    uft_ram #(
        .WIDTH (SW),
        .DEPTH (uft_pkg::NODES)
    ) u_size_ram (
        .aclk  (aclk),
        .we    (z_we),
        .waddr (z_waddr),
        .wdata (z_wdata),
        .raddr (z_raddr),
        .rdata (z_rdata)
    );

    always_comb begin
        active_next = active_reg;
        groups_next = groups_reg;
        clr_next = clr_reg;
        cmd_bit_next = cmd_bit_reg;
        a_next = a_reg;
        b_next = b_reg;
        node_next = node_reg;
        top_next = top_reg;
        walk_next = walk_reg;
        second_next = second_reg;
        bad_next = bad_reg;
        ra_next = ra_reg;
        rb_next = rb_reg;
        size_a_next = size_a_reg;
        size_b_next = size_b_reg;
        keep_next = keep_reg;
        merged_next = merged_reg;
        set_size_next = set_size_reg;
        out_ra_next = out_ra_reg;
        out_rb_next = out_rb_reg;
        out_same_next = out_same_reg;
        out_merged_next = out_merged_reg;
        out_size_next = out_size_reg;
        out_count_next = out_count_reg;
        out_bad_next = out_bad_reg;

        if (cmd.clear_step) begin
            clr_next = clr_reg + AW'(1);
        end
        if (cmd.accept) begin
            cmd_bit_next = s_command;
            a_next = AW'(s_first_index);
            b_next = AW'(s_second_index);
            node_next = AW'(s_first_index);
            second_next = 1'b0;
            merged_next = 1'b0;
            bad_next = status.in_bad;
        end
        if (cmd.find_start) begin
            top_next = node_reg;
        end
        if (cmd.find_up) begin
            if (status.link_is_top) begin
                walk_next = node_reg;
            end else begin
                top_next = p_rdata;
            end
        end
        if (cmd.compress) begin
            walk_next = p_rdata;
        end
        if (cmd.find_done) begin
            if (second_reg) begin
                rb_next = top_reg;
            end else begin
                ra_next = top_reg;
                node_next = b_reg;
                second_next = 1'b1;
            end
        end
        if (cmd.size_rb) begin
            size_a_next = z_rdata;
        end
        if (cmd.size_wait) begin
            size_b_next = z_rdata;
        end
        if (cmd.merge) begin
            if (do_merge) begin
                keep_next = keep_c;
                merged_next = 1'b1;
                set_size_next = size_sum;
                if (groups_reg != '0) begin
                    groups_next = groups_reg - CW'(1);
                end
            end else begin
                set_size_next = size_a_reg;
            end
        end
        if (cmd.out_load) begin
            out_bad_next = bad_reg;
            out_count_next = groups_reg;
            if (bad_reg) begin
                out_ra_next = '0;
                out_rb_next = '0;
                out_same_next = 1'b0;
                out_merged_next = 1'b0;
                out_size_next = '0;
            end else begin
                out_ra_next = IW'(ra_reg);
                out_rb_next = IW'(rb_reg);
                out_same_next = (ra_reg == rb_reg);
                out_merged_next = merged_reg;
                out_size_next = CW'(set_size_reg);
            end
        end
        if (cfg_wr_en) begin
            active_next = cfg_active;
            groups_next = cfg_active;
            clr_next = '0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= CW'(uft_pkg::RESET_ACTIVE);
            groups_reg <= CW'(uft_pkg::RESET_ACTIVE);
            clr_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
            groups_reg <= groups_next;
            clr_reg <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_bit_reg <= cmd_bit_next;
        a_reg <= a_next;
        b_reg <= b_next;
        node_reg <= node_next;
        top_reg <= top_next;
        walk_reg <= walk_next;
        second_reg <= second_next;
        bad_reg <= bad_next;
        ra_reg <= ra_next;
        rb_reg <= rb_next;
        size_a_reg <= size_a_next;
        size_b_reg <= size_b_next;
        keep_reg <= keep_next;
        merged_reg <= merged_next;
        set_size_reg <= set_size_next;
        out_ra_reg <= out_ra_next;
        out_rb_reg <= out_rb_next;
        out_same_reg <= out_same_next;
        out_merged_reg <= out_merged_next;
        out_size_reg <= out_size_next;
        out_count_reg <= out_count_next;
        out_bad_reg <= out_bad_next;
    end

    assign m_valid = m_valid_reg;
    assign m_first_root = out_ra_reg;
    assign m_second_root = out_rb_reg;
    assign m_same_set = out_same_reg;
    assign m_merged = out_merged_reg;
    assign m_set_size = out_size_reg;
    assign m_set_count = out_count_reg;
    assign m_bad_index = out_bad_reg;

endmodule

>>> rtl/union_find_table.sv
// Channel   Direction  Handshake           Payload
// cfg       in         cfg_wr_en           cfg_wr_data (element count)
// s         in         s_valid / s_ready   s_command, s_first_index, s_second_index
// m         out        m_valid / m_ready   roots, same_set, merged, size, count, bad_index
//
// One item at a time; a find walks the parent chain to the root, then compresses the path.
// A merge that repoints the first index adds a fix step; each parent hop waits
// on a registered RAM read.
// Reset and every count write start a clearing pass over all 1024 entries; s_ready stays low.
// An out-of-range item goes straight to the result; the result register frees s_ready early.
`include "union_find_table_assert.svh"

module union_find_table (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [uft_pkg::CNT_W-1:0]   cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_command,
    input  logic [uft_pkg::IDX_W-1:0]   s_first_index,
    input  logic [uft_pkg::IDX_W-1:0]   s_second_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [uft_pkg::IDX_W-1:0]   m_first_root,
    output logic [uft_pkg::IDX_W-1:0]   m_second_root,
    output logic                        m_same_set,
    output logic                        m_merged,
    output logic [uft_pkg::CNT_W-1:0]   m_set_size,
    output logic [uft_pkg::CNT_W-1:0]   m_set_count,
    output logic                        m_bad_index
);

    uft_pkg::dp_cmd_t    ctrl_cmd;
    uft_pkg::dp_status_t dp_status;

    uft_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .status    (dp_status),
        .cmd       (ctrl_cmd)
    );

    uft_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_command      (s_command),
        .s_first_index  (s_first_index),
        .s_second_index (s_second_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_first_root   (m_first_root),
        .m_second_root  (m_second_root),
        .m_same_set     (m_same_set),
        .m_merged       (m_merged),
        .m_set_size     (m_set_size),
        .m_set_count    (m_set_count),
        .m_bad_index    (m_bad_index),
        .cmd            (ctrl_cmd),
        .status         (dp_status)
    );

    `UFT_ASSERT_SAME(a_cmd_onehot, 1'b1, $onehot0(ctrl_cmd), "controller issued two commands")
    `UFT_ASSERT_NEXT(a_cfg_blocks, cfg_wr_en, !s_ready, "item accepted during clearing pass")
    `UFT_ASSERT_SAME(a_merge_distinct, m_valid && m_merged, !m_same_set && !m_bad_index,
                     "merge reported on one set or bad item")
    `UFT_ASSERT_SAME(a_bad_zero, m_valid && m_bad_index, (m_first_root == '0) &&
                     (m_second_root == '0) && (m_set_size == '0), "bad item has nonzero fields")

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int IW = uft_pkg::IDX_W;
    localparam int CW = uft_pkg::CNT_W;
    localparam longint TIMEOUT_NS = 64'd4_000_000;
    localparam int RANDOM_ITEMS = 650;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [IW-1:0] first_root;
        logic [IW-1:0] second_root;
        logic          same_set;
        logic          merged;
        logic [CW-1:0] set_size;
        logic [CW-1:0] set_count;
        logic          bad_index;
    } uf_answer_t;

    // Shadow copy of the disjoint-set table and the answers it still owes.
    class dsu_tracker;
        logic [IW-1:0] link [uft_pkg::NODES];
        logic [CW-1:0] weight [uft_pkg::NODES];
        int unsigned   sets_left;
        int unsigned   live;
        uf_answer_t    owed [$];
        int            mismatches;

        function new();
            mismatches = 0;
            reset_table(uft_pkg::RESET_COUNT);
        endfunction

        function void reset_table(int unsigned count);
            live = (count > uft_pkg::NODES) ? uft_pkg::NODES : count;
            for (int i = 0; i < uft_pkg::NODES; i++) begin
                link[i] = IW'(i);
                weight[i] = CW'(1);
            end
            sets_left = live;
        endfunction

        function int unsigned chase(int unsigned node);
            int unsigned top;
            int unsigned walk;
            int unsigned nxt;
            int unsigned hops;
            top = node;
            hops = 0;
            while (link[top] != top && hops < uft_pkg::NODES) begin
                top = link[top];
                hops++;
            end
            walk = node;
            hops = 0;
            while (walk != top && hops < uft_pkg::NODES) begin
                nxt = link[walk];
                link[walk] = IW'(top);
                walk = nxt;
                hops++;
            end
            return top;
        endfunction

        function void note_item(logic cmd, logic [IW-1:0] a, logic [IW-1:0] b);
            uf_answer_t  ans;
            int unsigned ra;
            int unsigned rb;
            int unsigned keep;
            int unsigned gone;
            ans = '0;
            if (a >= live || b >= live) begin
                ans.set_count = CW'(sets_left);
                ans.bad_index = 1'b1;
            end else begin
                ra = chase(a);
                rb = chase(b);
                ans.first_root = IW'(ra);
                ans.second_root = IW'(rb);
                ans.same_set = (ra == rb);
                if (cmd == uft_pkg::CMD_MERGE && ra != rb) begin
                    keep = ra;
                    gone = rb;
                    if (weight[ra] < weight[rb]) begin
                        keep = rb;
                        gone = ra;
                    end
                    weight[keep] = weight[keep] + weight[gone];
                    link[gone] = IW'(keep);
                    if (sets_left > 0) sets_left--;
                    ans.merged = 1'b1;
                end
                ans.set_size = weight[chase(a)];
                ans.set_count = CW'(sets_left);
            end
            owed.push_back(ans);
        endfunction

        function void check_result(uf_answer_t got);
            uf_answer_t want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("mismatch: result with no item outstanding, roots %0d/%0d",
                             got.first_root, got.second_root);
                end
            end else begin
                want = owed.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("mismatch: expected roots %0d/%0d same %0b merged %0b",
                                 want.first_root, want.second_root, want.same_set,
                                 want.merged);
                        $display("          size %0d count %0d bad %0b",
                                 want.set_size, want.set_count, want.bad_index);
                        $display("          got roots %0d/%0d same %0b merged %0b",
                                 got.first_root, got.second_root, got.same_set, got.merged);
                        $display("          size %0d count %0d bad %0b",
                                 got.set_size, got.set_count, got.bad_index);
                    end
                end
            end
        endfunction

        function int outstanding();
            return owed.size();
        endfunction
    endclass

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          cfg_wr_en = 1'b0;
    logic [CW-1:0] cfg_wr_data = '0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic          s_command = 1'b0;
    logic [IW-1:0] s_first_index = '0;
    logic [IW-1:0] s_second_index = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [IW-1:0] m_first_root;
    logic [IW-1:0] m_second_root;
    logic          m_same_set;
    logic          m_merged;
    logic [CW-1:0] m_set_size;
    logic [CW-1:0] m_set_count;
    logic          m_bad_index;

    dsu_tracker tracker;
    uf_answer_t seen;
    int         steady_feed = 0;
    int         rx_mode = 0;
    int         rx_span = 0;
    int         hold_off = 0;

    union_find_table i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_first_index  (s_first_index),
        .s_second_index (s_second_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_first_root   (m_first_root),
        .m_second_root  (m_second_root),
        .m_same_set     (m_same_set),
        .m_merged       (m_merged),
        .m_set_size     (m_set_size),
        .m_set_count    (m_set_count),
        .m_bad_index    (m_bad_index)
    );

    always #2 aclk = ~aclk;

    always @(negedge aclk) begin
        if (rx_span == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_span = $urandom_range(20, 200);
        end else begin
            rx_span--;
        end
        if (hold_off > 0) begin
            hold_off--;
            m_ready <= 1'b0;
        end else if (rx_mode != 0 && $urandom_range(0, 99) < ((rx_mode == 1) ? 25 : 4)) begin
            hold_off = (rx_mode == 1) ? $urandom_range(0, 2) : $urandom_range(8, 40);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen.first_root = m_first_root;
            seen.second_root = m_second_root;
            seen.same_set = m_same_set;
            seen.merged = m_merged;
            seen.set_size = m_set_size;
            seen.set_count = m_set_count;
            seen.bad_index = m_bad_index;
            tracker.check_result(seen);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_feed != 0) return 0;
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input logic cmd, input logic [IW-1:0] a,
                             input logic [IW-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_command <= cmd;
        s_first_index <= a;
        s_second_index <= b;
        do @(posedge aclk); while (!s_ready);
        tracker.note_item(cmd, a, b);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_count(input int unsigned value);
        settle();
        @(negedge aclk);
        cfg_wr_data <= CW'(value);
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.reset_table(value & 11'h7FF);
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int            random_sent;
        int unsigned   count;
        int unsigned   live;
        int            phase_len;
        int            r;
        logic          cmd;
        logic [IW-1:0] a;
        logic [IW-1:0] b;

        tracker = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_item(uft_pkg::CMD_QUERY, 10'd0, 10'd0);
        send_item(uft_pkg::CMD_QUERY, 10'd1023, 10'd1023);
        send_item(uft_pkg::CMD_MERGE, 10'd0, 10'd1023);
        send_item(uft_pkg::CMD_MERGE, 10'd1023, 10'd0);
        send_item(uft_pkg::CMD_QUERY, 10'd1023, 10'd1);
        send_item(uft_pkg::CMD_MERGE, 10'd1, 10'd2);
        send_item(uft_pkg::CMD_MERGE, 10'd3, 10'd1);
        send_item(uft_pkg::CMD_MERGE, 10'd8, 10'd9);
        send_item(uft_pkg::CMD_MERGE, 10'd10, 10'd11);
        send_item(uft_pkg::CMD_MERGE, 10'd8, 10'd10);
        send_item(uft_pkg::CMD_MERGE, 10'd12, 10'd13);
        send_item(uft_pkg::CMD_MERGE, 10'd14, 10'd15);
        send_item(uft_pkg::CMD_MERGE, 10'd12, 10'd14);
        send_item(uft_pkg::CMD_MERGE, 10'd11, 10'd15);
        send_item(uft_pkg::CMD_QUERY, 10'd15, 10'd11);
        send_item(uft_pkg::CMD_MERGE, 10'h2AA, 10'h155);

        write_count(2);
        send_item(uft_pkg::CMD_MERGE, 10'd0, 10'd1);
        send_item(uft_pkg::CMD_QUERY, 10'd2, 10'd0);
        send_item(uft_pkg::CMD_QUERY, 10'd0, 10'd2);
        send_item(uft_pkg::CMD_MERGE, 10'd1023, 10'd1023);
        write_count(0);
        send_item(uft_pkg::CMD_MERGE, 10'd0, 10'd0);
        write_count(1);
        send_item(uft_pkg::CMD_MERGE, 10'd0, 10'd0);
        send_item(uft_pkg::CMD_QUERY, 10'd1, 10'd0);
        write_count(2047);
        send_item(uft_pkg::CMD_QUERY, 10'd1023, 10'd0);
        send_item(uft_pkg::CMD_MERGE, 10'd1023, 10'd512);

        random_sent = 0;
        count = 1024;
        while (random_sent < RANDOM_ITEMS) begin
            write_count(count);
            live = (count > uft_pkg::NODES) ? uft_pkg::NODES : count;
            steady_feed = ($urandom_range(0, 3) == 0);
            phase_len = (live == 0) ? 8 : $urandom_range(20, 80);
            repeat (phase_len) begin
                cmd = ($urandom_range(0, 99) < 65) ? uft_pkg::CMD_MERGE : uft_pkg::CMD_QUERY;
                if (live > 0 && $urandom_range(0, 99) < 88) begin
                    a = IW'($urandom_range(0, live - 1));
                    b = IW'($urandom_range(0, live - 1));
                end else begin
                    a = IW'($urandom);
                    b = IW'($urandom);
                end
                send_item(cmd, a, b);
                random_sent++;
            end
            r = $urandom_range(0, 99);
            if (r < 60) count = $urandom_range(2, 40);
            else if (r < 75) count = $urandom_range(41, 300);
            else if (r < 85) count = 1024;
            else if (r < 90) count = $urandom_range(1025, 2047);
            else if (r < 95) count = 1;
            else count = 0;
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> union_find_table.f
+incdir+rtl
rtl/uft_pkg.sv
rtl/uft_ram.sv
rtl/uft_ctrl.sv
rtl/uft_dpath.sv
rtl/union_find_table.sv
tb/tb.sv
